[rtl/bale_pkg.sv]
// ----------------------------------------------------------------------------
// bale_pkg
// Shared types, field widths, request and status codes for the bounded
// array list engine.
// ----------------------------------------------------------------------------
package bale_pkg;

  // Fixed field widths of the request and result channels.
  localparam int unsigned DataW   = 32;
  localparam int unsigned TypeW   = 3;
  localparam int unsigned IdxW    = 8;
  localparam int unsigned StatusW = 3;

  // Default number of list entries.
  localparam int unsigned DefCapacity = 256;

  // Request codes.
  localparam logic [TypeW-1:0] ReqAppend = 3'd0;
  localparam logic [TypeW-1:0] ReqInsert = 3'd1;
  localparam logic [TypeW-1:0] ReqRemIdx = 3'd2;
  localparam logic [TypeW-1:0] ReqRemVal = 3'd3;
  localparam logic [TypeW-1:0] ReqGet    = 3'd4;

  // Status codes.
  localparam logic [StatusW-1:0] StOk       = 3'd0;
  localparam logic [StatusW-1:0] StBadIndex = 3'd1;
  localparam logic [StatusW-1:0] StEmpty    = 3'd2;
  localparam logic [StatusW-1:0] StNotFound = 3'd3;
  localparam logic [StatusW-1:0] StFull     = 3'd4;

  // Command from the sequencer that launches one pass of the shift walker.
  typedef struct packed {
    logic start;   // load pointer and remaining count this cycle
    logic down;    // walk toward lower addresses, moving entries up
    logic found;   // up walk: entries already move down by one place
  } walk_cmd_t;

  // Status of the shift walker back to the sequencer.
  typedef struct packed {
    logic busy;    // reads still to issue or read data still to consume
    logic found;   // up walk: a match was seen or removal was forced
  } walk_sts_t;

endpackage

[rtl/bale_ram.sv]
// ----------------------------------------------------------------------------
// bale_ram
// Generic single-clock RAM with one write port and one read port. The read
// data is registered and holds its value when no read is issued.
// ----------------------------------------------------------------------------
module bale_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/bale_walker.sv]
// ----------------------------------------------------------------------------
// bale_walker
// Shared shift and search unit. It walks a run of entries one read per
// cycle; a down walk writes each read word one place up, an up walk writes
// each one place down once found, comparing with the search key until then.
// ----------------------------------------------------------------------------
module bale_walker
  import bale_pkg::*;
#(
  parameter int unsigned AddrW = 8,
  parameter int unsigned LenW  = 9
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  walk_cmd_t        cmd_i,
  input  logic [AddrW-1:0] ptr0_i,
  input  logic [LenW-1:0]  rem0_i,
  input  logic [DataW-1:0] key_i,
  input  logic [DataW-1:0] rd_data_i,
  output walk_sts_t        sts_o,
  output logic             rd_en_o,
  output logic [AddrW-1:0] rd_addr_o,
  output logic             wr_en_o,
  output logic [AddrW-1:0] wr_addr_o,
  output logic [DataW-1:0] wr_data_o
);

  logic [AddrW-1:0] ptr_q, ptr_d;
  logic [AddrW-1:0] pos_q, pos_d;
  logic [LenW-1:0]  rem_q, rem_d;
  logic             rv_q, rv_d;
  logic             down_q, down_d;
  logic             found_q, found_d;
  logic             issue;
  logic             match;

  assign issue = (rem_q != '0);
  assign match = (rd_data_i == key_i);

  // Pointer stepping and match tracking.
  always_comb begin
    ptr_d   = ptr_q;
    pos_d   = pos_q;
    rem_d   = rem_q;
    rv_d    = 1'b0;
    down_d  = down_q;
    found_d = found_q;
    if (cmd_i.start) begin
      ptr_d   = ptr0_i;
      rem_d   = rem0_i;
      down_d  = cmd_i.down;
      found_d = cmd_i.found;
    end else begin
      if (issue) begin
        ptr_d = down_q ? (ptr_q - AddrW'(1)) : (ptr_q + AddrW'(1));
        rem_d = rem_q - LenW'(1);
        pos_d = ptr_q;
        rv_d  = 1'b1;
      end
      if (rv_q && !down_q && !found_q && match) begin
        found_d = 1'b1;
      end
    end
  end

  // The read data of the previous cycle is written back one place over.
  always_comb begin
    wr_en_o   = 1'b0;
    wr_addr_o = pos_q + AddrW'(1);
    if (rv_q) begin
      if (down_q) begin
        wr_en_o = 1'b1;
      end else begin
        wr_en_o   = found_q;
        wr_addr_o = pos_q - AddrW'(1);
      end
    end
  end

  assign wr_data_o  = rd_data_i;
  assign rd_en_o    = issue && !cmd_i.start;
  assign rd_addr_o  = ptr_q;
  assign sts_o.busy  = issue || rv_q;
  assign sts_o.found = found_q;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q   <= '0;
      rv_q    <= 1'b0;
      down_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      rem_q   <= rem_d;
      rv_q    <= rv_d;
      down_q  <= down_d;
      found_q <= found_d;
    end
  end

  // Address registers.
  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    pos_q <= pos_d;
  end

endmodule

[rtl/bounded_array_list_engine.sv]
// ----------------------------------------------------------------------------
// bounded_array_list_engine
// Fixed-capacity ordered list of signed words with append, insert, remove
// at index, remove by value and get. Entries live in one RAM; shifts and
// searches run through a shared walker that reads one entry while it writes back the one before.
// ----------------------------------------------------------------------------
// Sequence: every request passes SDecide and SOut; insert, remove at index
// and remove by value walk the entries in SWalk when they go ahead, an
// insert then fills its gap in SFinIns, and a valid get reads in SGet.
// Throughput: one request at a time; in_stall_o is low only when idle.
// Reset: the entry count and all control state clear at once; the RAM is
// not cleared, since only entries below the count are ever read.
module bounded_array_list_engine
  import bale_pkg::*;
#(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [TypeW-1:0]                  req_type_i,
  input  logic signed [DataW-1:0]           value_i,
  input  logic [IdxW-1:0]                   index_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [DataW-1:0]           read_value_o,
  output logic [StatusW-1:0]                status_o,
  output logic [$clog2(CAPACITY+1)-1:0]     length_o
);

  localparam int unsigned AddrW = $clog2(CAPACITY);
  localparam int unsigned LenW  = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW  = (LenW > IdxW) ? LenW : IdxW;

  // Sequencer states.
  localparam logic [2:0] SIdle   = 3'd0;
  localparam logic [2:0] SDecide = 3'd1;
  localparam logic [2:0] SWalk   = 3'd2;
  localparam logic [2:0] SFinIns = 3'd3;
  localparam logic [2:0] SGet    = 3'd4;
  localparam logic [2:0] SOut    = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [LenW-1:0]    count_q, count_d;
  logic [TypeW-1:0]   req_q;
  logic [DataW-1:0]   val_q;
  logic [IdxW-1:0]    idx_q;
  logic [DataW-1:0]   res_rd_q, res_rd_d;
  logic [StatusW-1:0] res_st_q, res_st_d;
  logic               out_valid_q, out_valid_d;
  logic [DataW-1:0]   out_rd_q;
  logic [StatusW-1:0] out_st_q;
  logic [LenW-1:0]    out_len_q;
  logic               in_xfer;
  logic               out_load;

  // Compare operands.
  logic [CmpW-1:0] idx_x;
  logic [CmpW-1:0] cnt_x;
  logic            full;
  logic            empty;
  logic            idx_ok;

  // RAM ports.
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [DataW-1:0] ram_wdata;
  logic             ram_re;
  logic [AddrW-1:0] ram_raddr;
  logic [DataW-1:0] ram_rdata;

  // Walker ports.
  walk_cmd_t        wcmd;
  walk_sts_t        wsts;
  logic [AddrW-1:0] wptr0;
  logic [LenW-1:0]  wrem0;
  logic             w_re;
  logic [AddrW-1:0] w_raddr;
  logic             w_we;
  logic [AddrW-1:0] w_waddr;
  logic [DataW-1:0] w_wdata;

  assign in_stall_o = (state_q != SIdle);
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign idx_x  = CmpW'(idx_q);
  assign cnt_x  = CmpW'(count_q);
  assign full   = (count_q == LenW'(CAPACITY));
  assign empty  = (count_q == '0);
  assign idx_ok = (idx_x < cnt_x);

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q <= req_type_i;
      val_q <= value_i;
      idx_q <= index_i;
    end
  end

  // Sequencer: decides each request and drives direct RAM accesses.
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    res_rd_d  = res_rd_q;
    res_st_d  = res_st_q;
    wcmd      = '0;
    wptr0     = '0;
    wrem0     = '0;
    ram_we    = 1'b0;
    ram_waddr = count_q[AddrW-1:0];
    ram_wdata = val_q;
    ram_re    = 1'b0;
    ram_raddr = AddrW'(idx_q);
    out_load  = 1'b0;
    case (state_q)
      SIdle: begin
        if (in_xfer) begin
          state_d = SDecide;
        end
      end
      SDecide: begin
        res_rd_d = '0;
        res_st_d = StOk;
        state_d  = SOut;
        case (req_q)
          ReqAppend: begin
            if (full) begin
              res_st_d = StFull;
            end else begin
              ram_we  = 1'b1;
              count_d = count_q + LenW'(1);
            end
          end
          ReqInsert: begin
            if (empty && (idx_q == '0)) begin
              ram_we  = 1'b1;
              count_d = count_q + LenW'(1);
            end else if (!idx_ok) begin
              res_st_d = StBadIndex;
            end else if (full) begin
              res_st_d = StFull;
            end else begin
              wcmd.start = 1'b1;
              wcmd.down  = 1'b1;
              wptr0      = AddrW'(count_q - LenW'(1));
              wrem0      = LenW'(cnt_x - idx_x);
              state_d    = SWalk;
            end
          end
          ReqRemIdx: begin
            if (empty) begin
              res_st_d = StEmpty;
            end else if (!idx_ok) begin
              res_st_d = StBadIndex;
            end else begin
              wcmd.start = 1'b1;
              wcmd.found = 1'b1;
              wptr0      = AddrW'(idx_x + CmpW'(1));
              wrem0      = LenW'(cnt_x - idx_x - CmpW'(1));
              state_d    = SWalk;
            end
          end
          ReqRemVal: begin
            wcmd.start = 1'b1;
            wptr0      = '0;
            wrem0      = count_q;
            state_d    = SWalk;
          end
          ReqGet: begin
            if (idx_ok) begin
              ram_re  = 1'b1;
              state_d = SGet;
            end else begin
              res_rd_d = '1;
              res_st_d = StBadIndex;
            end
          end
          default: begin
            res_st_d = StBadIndex;
          end
        endcase
      end
      SWalk: begin
        if (!wsts.busy) begin
          if (req_q == ReqInsert) begin
            state_d = SFinIns;
          end else begin
            if (wsts.found) begin
              count_d = count_q - LenW'(1);
            end else begin
              res_st_d = StNotFound;
            end
            state_d = SOut;
          end
        end
      end
      SFinIns: begin
        // The gap at the insert position takes the new word.
        ram_we    = 1'b1;
        ram_waddr = AddrW'(idx_q);
        count_d   = count_q + LenW'(1);
        state_d   = SOut;
      end
      SGet: begin
        res_rd_d = ram_rdata;
        state_d  = SOut;
      end
      SOut: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase

    // The walker owns the RAM while a walk is in flight.
    if (state_q == SWalk) begin
      ram_we    = w_we;
      ram_waddr = w_waddr;
      ram_wdata = w_wdata;
      ram_re    = w_re;
      ram_raddr = w_raddr;
    end
  end

  // Result register toward the output channel.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    res_rd_q <= res_rd_d;
    res_st_q <= res_st_d;
    if (out_load) begin
      out_rd_q  <= res_rd_q;
      out_st_q  <= res_st_q;
      out_len_q <= count_q;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_rd_q;
  assign status_o     = out_st_q;
  assign length_o     = out_len_q;

  // Entry storage.
  bale_ram #(
    .Width (DataW),
    .Depth (CAPACITY)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata),
    .rd_en_i   (ram_re),
    .rd_addr_i (ram_raddr),
    .rd_data_o (ram_rdata)
  );

  // Shift and search unit.
  bale_walker #(
    .AddrW (AddrW),
    .LenW  (LenW)
  ) u_walker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (wcmd),
    .ptr0_i    (wptr0),
    .rem0_i    (wrem0),
    .key_i     (val_q),
    .rd_data_i (ram_rdata),
    .sts_o     (wsts),
    .rd_en_o   (w_re),
    .rd_addr_o (w_raddr),
    .wr_en_o   (w_we),
    .wr_addr_o (w_waddr),
    .wr_data_o (w_wdata)
  );

endmodule

[tb/bounded_array_list_engine_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_array_list_engine_tb
// Self-checking bench for the bounded array list engine. A plan of requests
// is built up front, with the list contents tracked so that indexes and
// search values land on live entries. A clocked driver sends the plan in
// random bursts. A shadow copy of the list predicts each reply, and a
// clocked monitor compares every reply field by field. The receiver stalls
// on changing patterns, including one long hold-off that backs up the block.
// ----------------------------------------------------------------------------
module bounded_array_list_engine_tb;
  import bale_pkg::*;

  localparam int unsigned Capacity      = DefCapacity;
  localparam int unsigned LenW          = $clog2(Capacity + 1);
  localparam int unsigned PlanItems     = 950;
  localparam int unsigned HoldoffCycles = 700;
  localparam int unsigned TailCycles    = 300;
  localparam int unsigned CycleLimit    = 1_500_000;
  localparam int unsigned MaxPrinted    = 40;

  // The two copies of the list: one steers the plan, one predicts replies.
  localparam int unsigned PlanSide   = 0;
  localparam int unsigned ShadowSide = 1;

  // Request codes that the block has no operation for.
  localparam logic [TypeW-1:0] ReqRsvd5 = 3'd5;
  localparam logic [TypeW-1:0] ReqRsvd6 = 3'd6;
  localparam logic [TypeW-1:0] ReqRsvd7 = 3'd7;

  localparam logic signed [DataW-1:0] MinWord  = 32'sh8000_0000;
  localparam logic signed [DataW-1:0] MaxWord  = 32'sh7fff_ffff;
  localparam logic signed [DataW-1:0] ReadMiss = -32'sd1;

  typedef struct packed {
    logic [TypeW-1:0]        kind;
    logic signed [DataW-1:0] value;
    logic [IdxW-1:0]         index;
    logic                    drain;   // hold back until every reply is in
  } list_req_t;

  typedef struct packed {
    logic signed [DataW-1:0] read_value;
    logic [StatusW-1:0]      status;
    logic [LenW-1:0]         length;
  } list_reply_t;

  typedef enum logic [1:0] {
    StallNone,
    StallLight,
    StallHeavy,
    StallToggle
  } stall_mode_e;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_stall_o;
  logic [TypeW-1:0]        req_type_i  = ReqAppend;
  logic signed [DataW-1:0] value_i     = '0;
  logic [IdxW-1:0]         index_i     = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [DataW-1:0] read_value_o;
  logic [StatusW-1:0]      status_o;
  logic [LenW-1:0]         length_o;

  // List contents for the plan copy and the shadow copy.
  logic signed [DataW-1:0] list_words [2][Capacity];
  int unsigned             list_len   [2];

  list_req_t   request_backlog [$];
  list_reply_t owed_replies    [$];

  int unsigned requests_taken;
  int unsigned replies_taken;
  int unsigned mismatch_count = 0;
  int unsigned planned_total  = 0;
  int unsigned cycle_count    = 0;
  logic signed [DataW-1:0] value_pool [6];

  // Driver-private state.
  list_req_t   offered;
  list_reply_t reply;
  logic        took_request;
  int unsigned burst_left;
  int unsigned gap_left;

  // Monitor and receiver private state.
  list_reply_t due;
  int unsigned holdoff_left;
  logic        holdoff_done;
  stall_mode_e stall_mode;
  int unsigned mode_left;

  bounded_array_list_engine #(
    .CAPACITY(Capacity)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .value_i     (value_i),
    .index_i     (index_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .read_value_o(read_value_o),
    .status_o    (status_o),
    .length_o    (length_o)
  );

  always #10 clk_i = ~clk_i;

  // Applies one request to one copy of the list and returns its reply.
  task automatic apply_list_op(input int unsigned side, input list_req_t rq,
                               output list_reply_t rs);
    int unsigned n;
    int unsigned pos;
    int unsigned k;
    logic        hit;
    rs  = '0;
    n   = list_len[side];
    pos = rq.index;
    hit = 1'b0;
    case (rq.kind)
      ReqAppend: begin
        if (n >= Capacity) begin
          rs.status = StFull;
        end else begin
          list_words[side][n] = rq.value;
          n++;
        end
      end
      ReqInsert: begin
        if (n == 0 && pos == 0) begin
          list_words[side][0] = rq.value;
          n = 1;
        end else if (pos >= n) begin
          rs.status = StBadIndex;
        end else if (n >= Capacity) begin
          rs.status = StFull;
        end else begin
          for (k = n; k > pos; k--) list_words[side][k] = list_words[side][k-1];
          list_words[side][pos] = rq.value;
          n++;
        end
      end
      ReqRemIdx: begin
        if (n == 0) begin
          rs.status = StEmpty;
        end else if (pos >= n) begin
          rs.status = StBadIndex;
        end else begin
          hit = 1'b1;
        end
      end
      ReqRemVal: begin
        rs.status = StNotFound;
        for (k = 0; k < n; k++) begin
          if (!hit && list_words[side][k] == rq.value) begin
            hit = 1'b1;
            pos = k;
          end
        end
        if (hit) rs.status = StOk;
      end
      ReqGet: begin
        if (pos < n) begin
          rs.read_value = list_words[side][pos];
        end else begin
          rs.read_value = ReadMiss;
          rs.status     = StBadIndex;
        end
      end
      default: begin
        rs.status = StBadIndex;
      end
    endcase
    // Both removals close the gap left at pos.
    if (hit) begin
      for (k = pos; k + 1 < n; k++) list_words[side][k] = list_words[side][k+1];
      n--;
    end
    list_len[side] = n;
    rs.length      = LenW'(n);
  endtask

  task automatic flag_mismatch(input string what);
    if (mismatch_count < MaxPrinted) $display("mismatch: %s", what);
    mismatch_count++;
  endtask

  task automatic plan_request(input logic [TypeW-1:0] kind,
                              input logic signed [DataW-1:0] value,
                              input logic [IdxW-1:0] index, input logic drain);
    list_req_t   rq;
    list_reply_t ignored;
    rq.kind  = kind;
    rq.value = value;
    rq.index = index;
    rq.drain = drain;
    apply_list_op(PlanSide, rq, ignored);
    request_backlog.push_back(rq);
  endtask

  // Values repeat often, and often match a live entry, so searches hit.
  function automatic logic signed [DataW-1:0] pick_value();
    int unsigned n;
    int unsigned r;
    n = list_len[PlanSide];
    r = $urandom_range(0, 9);
    if (n > 0 && r < 3) return list_words[PlanSide][$urandom_range(0, n - 1)];
    if (r < 7) return value_pool[$urandom_range(0, 5)];
    return $urandom;
  endfunction

  // Mostly live positions, some at the count, the rest anywhere.
  function automatic logic [IdxW-1:0] pick_index();
    int unsigned n;
    int unsigned r;
    n = list_len[PlanSide];
    r = $urandom_range(0, 9);
    if (n > 0 && r < 7) return IdxW'($urandom_range(0, n - 1));
    if (r < 8 && n < Capacity) return IdxW'(n);
    return IdxW'($urandom_range(0, 255));
  endfunction

  task automatic plan_random(input int unsigned w_app, input int unsigned w_ins,
                             input int unsigned w_rix, input int unsigned w_rvl,
                             input int unsigned w_get);
    int unsigned      roll;
    logic [TypeW-1:0] kind;
    roll = $urandom_range(0, w_app + w_ins + w_rix + w_rvl + w_get + 2);
    if (roll < w_app) kind = ReqAppend;
    else if (roll < w_app + w_ins) kind = ReqInsert;
    else if (roll < w_app + w_ins + w_rix) kind = ReqRemIdx;
    else if (roll < w_app + w_ins + w_rix + w_rvl) kind = ReqRemVal;
    else if (roll < w_app + w_ins + w_rix + w_rvl + w_get) kind = ReqGet;
    else begin
      case ($urandom_range(0, 2))
        0:       kind = ReqRsvd5;
        1:       kind = ReqRsvd6;
        default: kind = ReqRsvd7;
      endcase
    end
    plan_request(kind, pick_value(), pick_index(), 1'b0);
  endtask

  // Sender: offers the backlog in bursts, holding each offer until transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      requests_taken <= 0;
      burst_left     = 0;
      gap_left       = 0;
    end else begin
      took_request = in_valid_i && !in_stall_o;
      if (took_request) begin
        apply_list_op(ShadowSide, offered, reply);
        owed_replies.push_back(reply);
        requests_taken <= requests_taken + 1;
      end
      if (!in_valid_i || took_request) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (request_backlog.size() != 0 &&
                     (!request_backlog[0].drain ||
                      requests_taken + took_request == replies_taken)) begin
          offered = request_backlog.pop_front();
          req_type_i <= offered.kind;
          value_i    <= offered.value;
          index_i    <= offered.index;
          in_valid_i <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            case ($urandom_range(0, 9))
              0, 1, 2: gap_left = 0;
              9:       gap_left = $urandom_range(20, 60);
              default: gap_left = $urandom_range(1, 8);
            endcase
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: each reply transfer is checked against the oldest owed reply.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      replies_taken <= 0;
    end else if (out_valid_o && !out_stall_i) begin
      replies_taken <= replies_taken + 1;
      if (owed_replies.size() == 0) begin
        flag_mismatch($sformatf("reply %0d arrived with none owed", replies_taken));
      end else begin
        due = owed_replies.pop_front();
        if (read_value_o !== due.read_value)
          flag_mismatch($sformatf("reply %0d read_value %0d, predicted %0d",
                                  replies_taken, read_value_o, due.read_value));
        if (status_o !== due.status)
          flag_mismatch($sformatf("reply %0d status %0d, predicted %0d",
                                  replies_taken, status_o, due.status));
        if (length_o !== due.length)
          flag_mismatch($sformatf("reply %0d length %0d, predicted %0d",
                                  replies_taken, length_o, due.length));
      end
    end
  end

  // Receiver stall: one long hold-off, otherwise a pattern that changes.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i  <= 1'b0;
      holdoff_left = 0;
      holdoff_done = 1'b0;
      stall_mode   = StallNone;
      mode_left    = 0;
    end else if (holdoff_left > 0) begin
      holdoff_left--;
      out_stall_i <= 1'b1;
    end else if (!holdoff_done && requests_taken >= 120) begin
      holdoff_done = 1'b1;
      holdoff_left = HoldoffCycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left  = $urandom_range(20, 300);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        StallNone:  out_stall_i <= 1'b0;
        StallLight: out_stall_i <= ($urandom_range(0, 3) == 0);
        StallHeavy: out_stall_i <= ($urandom_range(0, 3) != 0);
        default:    out_stall_i <= ~out_stall_i;
      endcase
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[bounded_array_list_engine] ERROR");
      $finish;
    end
  end

  initial begin
    list_len[PlanSide]   = 0;
    list_len[ShadowSide] = 0;
    value_pool[0] = MinWord;
    value_pool[1] = MaxWord;
    value_pool[2] = -32'sd1;
    value_pool[3] = 32'sd0;
    value_pool[4] = $urandom;
    value_pool[5] = $urandom;

    // Directed: empty-list cases, field extremes, first match, bad codes.
    plan_request(ReqRemIdx, 32'sd0, 8'd0, 1'b0);
    plan_request(ReqRemVal, 32'sd42, 8'd0, 1'b0);
    plan_request(ReqGet, 32'sd0, 8'd0, 1'b0);
    plan_request(ReqInsert, 32'sd7, 8'd5, 1'b0);
    plan_request(ReqInsert, MinWord, 8'd0, 1'b0);
    plan_request(ReqAppend, MaxWord, 8'd255, 1'b0);
    plan_request(ReqAppend, -32'sd1, 8'd0, 1'b0);
    plan_request(ReqAppend, 32'sd0, 8'd0, 1'b0);
    plan_request(ReqInsert, 32'sd42, 8'd0, 1'b0);
    plan_request(ReqInsert, 32'sd42, 8'd2, 1'b0);
    plan_request(ReqInsert, 32'sd9, 8'd6, 1'b0);
    plan_request(ReqGet, 32'sd0, 8'd255, 1'b0);
    plan_request(ReqGet, 32'sd0, 8'd2, 1'b0);
    plan_request(ReqRemVal, 32'sd42, 8'd0, 1'b0);
    plan_request(ReqGet, 32'sd0, 8'd0, 1'b0);
    plan_request(ReqRemIdx, 32'sd0, 8'd4, 1'b0);
    plan_request(ReqRemIdx, 32'sd0, 8'd4, 1'b0);
    plan_request(ReqRemVal, 32'sd5, 8'd0, 1'b0);
    plan_request(ReqRsvd5, $urandom, IdxW'($urandom), 1'b0);
    plan_request(ReqRsvd6, MinWord, 8'd0, 1'b0);
    plan_request(ReqRsvd7, -32'sd1, 8'd255, 1'b0);
    plan_request(ReqRemIdx, 32'sd0, 8'd0, 1'b0);
    plan_request(ReqGet, 32'sd0, 8'd1, 1'b0);
    plan_request(ReqRemVal, -32'sd1, 8'd0, 1'b0);
    plan_request(ReqAppend, 32'sh5555_5555, 8'haa, 1'b0);

    // Random growth, first item waits for the directed replies.
    plan_request(ReqGet, 32'sd0, pick_index(), 1'b1);
    repeat (250) plan_random(30, 25, 15, 15, 12);

    // Fill to capacity, then exercise the full list.
    plan_request(ReqAppend, pick_value(), IdxW'($urandom), 1'b1);
    while (list_len[PlanSide] < Capacity)
      plan_request(ReqAppend, pick_value(), IdxW'($urandom), 1'b0);
    plan_request(ReqAppend, $urandom, 8'd0, 1'b0);
    plan_request(ReqInsert, $urandom, 8'd10, 1'b0);
    plan_request(ReqInsert, $urandom, 8'd255, 1'b0);
    plan_request(ReqGet, 32'sd0, 8'd255, 1'b0);
    plan_request(ReqRemIdx, 32'sd0, 8'd255, 1'b0);
    plan_request(ReqGet, 32'sd0, 8'd255, 1'b0);
    plan_request(ReqInsert, MaxWord, 8'd0, 1'b0);
    plan_request(ReqAppend, MinWord, 8'd0, 1'b0);
    plan_request(ReqGet, 32'sd0, 8'd0, 1'b0);

    // Random shrink back down through the rest of the plan.
    while (request_backlog.size() < PlanItems) plan_random(15, 12, 30, 25, 15);
    planned_total = request_backlog.size();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (requests_taken == planned_total);
    wait (replies_taken == requests_taken);
    repeat (TailCycles) @(posedge clk_i);

    if (owed_replies.size() != 0)
      flag_mismatch($sformatf("%0d replies never arrived", owed_replies.size()));
    if (mismatch_count == 0) begin
      $display("[bounded_array_list_engine] OK");
    end else begin
      $display("[bounded_array_list_engine] ERROR");
    end
    $finish;
  end

endmodule

[bounded_array_list_engine.f]
rtl/bale_pkg.sv
rtl/bale_ram.sv
rtl/bale_walker.sv
rtl/bounded_array_list_engine.sv
tb/bounded_array_list_engine_tb.sv
